// File: hdl/i2cms_pkg.sv
package i2cms_pkg;

	// Command codes carried in the mode field
	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_WAIT  = 3'd5
	} cmd_t;

	localparam logic [7:0] TIMEOUT_RESET = 8'd250;
	localparam logic [8:0] WAIT_MAX      = 9'h1FF;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Register map: index taken from paddr[2]
	localparam int unsigned PADDR_W  = 3;
	localparam logic REG_ACK_TIMEOUT = 1'b0;

	// One accepted command/tick transaction
	typedef struct packed {
		logic [2:0] mode;
		logic       sda_sample;
		logic [7:0] tx_byte;
		logic       lsb_first;
		logic       send_ack;
	} cmd_item_t;

	// One result transaction
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} res_item_t;

	// Sequencer state carried between transactions
	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] phase;
		logic [3:0] bit_cnt;
		logic [7:0] shift;
		logic [8:0] wait_cnt;
		logic       scl;
		logic       sda;
		logic       sda_en;
		logic       ack_sel;
		logic       lsb_sel;
		logic       err;
		logic [7:0] rx_hold;
	} seq_state_t;

endpackage

// File: hdl/i2cms_if.sv
interface i2cms_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic       sda_sample;
	logic [7:0] tx_byte;
	logic       lsb_first;
	logic       send_ack;

	modport source (output valid, mode, sda_sample, tx_byte, lsb_first, send_ack,
		input ready);
	modport sink (input valid, mode, sda_sample, tx_byte, lsb_first, send_ack,
		output ready);
endinterface

interface i2cms_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_missing;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_missing, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_missing, output ready);
endinterface

// File: hdl/i2cms_regs.sv
module i2cms_regs
	import i2cms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [7:0]         ack_timeout
);

	logic [7:0] ack_timeout_q;

	assign pready = 1'b1;

	// Register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACK_TIMEOUT) begin
			ack_timeout_q <= pwdata[7:0];
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ACK_TIMEOUT) begin
			prdata = {24'd0, ack_timeout_q};
		end
	end

	assign ack_timeout = ack_timeout_q;

endmodule

// File: hdl/i2cms_step.sv
module i2cms_step
	import i2cms_pkg::*;
(
	input  seq_state_t cur,
	input  cmd_item_t  item,
	input  logic [7:0] ack_timeout,
	output seq_state_t nxt,
	output res_item_t  res
);

	logic done;

	always_comb begin
		nxt  = cur;
		done = 1'b0;

		// Take a new command only while idle
		if (cur.cmd == CMD_IDLE && item.mode >= CMD_START && item.mode <= CMD_WAIT) begin
			nxt.cmd      = cmd_t'(item.mode);
			nxt.phase    = 2'd0;
			nxt.bit_cnt  = 4'd0;
			nxt.wait_cnt = 9'd0;
			nxt.err      = 1'b0;
			nxt.shift    = (item.mode == CMD_WRITE) ? item.tx_byte : 8'd0;
			nxt.lsb_sel  = item.lsb_first;
			nxt.ack_sel  = item.send_ack;
		end

		// One pin phase
		unique case (nxt.cmd)
			CMD_IDLE: begin
			end
			CMD_START: begin
				if (nxt.phase == 2'd0) begin
					nxt.sda_en = 1'b1; nxt.sda = 1'b1; nxt.scl = 1'b1; nxt.phase = 2'd1;
				end else if (nxt.phase == 2'd1) begin
					nxt.sda = 1'b0; nxt.phase = 2'd2;
				end else begin
					nxt.scl = 1'b0; done = 1'b1;
				end
			end
			CMD_STOP: begin
				if (nxt.phase == 2'd0) begin
					nxt.sda_en = 1'b1; nxt.sda = 1'b0; nxt.scl = 1'b0; nxt.phase = 2'd1;
				end else if (nxt.phase == 2'd1) begin
					nxt.scl = 1'b1; nxt.phase = 2'd2;
				end else begin
					nxt.sda = 1'b1; done = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (nxt.bit_cnt < BITS_PER_BYTE) begin
					if (nxt.phase == 2'd0) begin
						nxt.sda_en = 1'b1;
						nxt.scl    = 1'b0;
						if (nxt.lsb_sel) begin
							nxt.sda   = nxt.shift[0];
							nxt.shift = {1'b0, nxt.shift[7:1]};
						end else begin
							nxt.sda   = nxt.shift[7];
							nxt.shift = {nxt.shift[6:0], 1'b0};
						end
						nxt.phase = 2'd1;
					end else begin
						nxt.scl = 1'b1; nxt.phase = 2'd0; nxt.bit_cnt = nxt.bit_cnt + 4'd1;
					end
				end else begin
					nxt.scl = 1'b0; done = 1'b1;
				end
			end
			CMD_READ: begin
				if (nxt.bit_cnt < BITS_PER_BYTE) begin
					if (nxt.phase == 2'd0) begin
						nxt.scl = 1'b0; nxt.sda_en = 1'b0; nxt.sda = 1'b1; nxt.phase = 2'd1;
					end else begin
						nxt.scl     = 1'b1;
						nxt.shift   = {nxt.shift[6:0], item.sda_sample};
						nxt.bit_cnt = nxt.bit_cnt + 4'd1;
						nxt.phase   = 2'd0;
						if (nxt.bit_cnt == BITS_PER_BYTE) begin
							nxt.rx_hold = nxt.shift;
						end
					end
				end else if (nxt.phase == 2'd0) begin
					// ACK low or NACK high
					nxt.scl = 1'b0; nxt.sda_en = 1'b1; nxt.sda = !nxt.ack_sel; nxt.phase = 2'd1;
				end else if (nxt.phase == 2'd1) begin
					nxt.scl = 1'b1; nxt.phase = 2'd2;
				end else begin
					nxt.scl = 1'b0; done = 1'b1;
				end
			end
			CMD_WAIT: begin
				if (nxt.phase == 2'd0) begin
					nxt.sda_en = 1'b0; nxt.sda = 1'b1; nxt.scl = 1'b1;
					nxt.wait_cnt = 9'd0; nxt.phase = 2'd1;
				end
				if (!item.sda_sample) begin
					nxt.scl = 1'b0; done = 1'b1;
				end else begin
					if (nxt.wait_cnt != WAIT_MAX) begin
						nxt.wait_cnt = nxt.wait_cnt + 9'd1;
					end
					// Timeout: flag it and run a stop from the next transaction
					if (nxt.wait_cnt > {1'b0, ack_timeout}) begin
						nxt.err     = 1'b1;
						nxt.cmd     = CMD_STOP;
						nxt.phase   = 2'd0;
						nxt.bit_cnt = 4'd0;
					end
				end
			end
			default: begin
				nxt.cmd = CMD_IDLE;
			end
		endcase

		if (done) begin
			nxt.cmd     = CMD_IDLE;
			nxt.phase   = 2'd0;
			nxt.bit_cnt = 4'd0;
		end

		res.scl_level   = nxt.scl;
		res.sda_level   = nxt.sda_en ? nxt.sda : 1'b1;
		res.sda_drive   = nxt.sda_en;
		res.busy_res    = (nxt.cmd != CMD_IDLE);
		res.done_res    = done;
		res.rx_byte     = nxt.rx_hold;
		res.ack_missing = nxt.err;
	end

endmodule

// File: hdl/i2c_master_bit_sequencer_unit.sv
// I2C master bit sequencer: one bus phase per transaction.
// Pipeline: input register, then result register; an accepted transaction moves on into the
// result register once that slot frees up. A stalled result holds the input register.
// Throughput: 1 transaction per cycle if unstalled; the phase step is one combinational pass.
// Reset (arst_n low, asynchronous): idle, SCL/SDA released high, SDA not driven,
// ack_timeout = 250, both pipeline stages empty.
module i2c_master_bit_sequencer_unit
	import i2cms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	i2cms_cmd_if.sink          cmd,
	i2cms_res_if.source        res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic       [7:0] ack_timeout;
	cmd_item_t        item_s1;
	logic             vld_s1;
	seq_state_t       state_q;
	seq_state_t       state_nxt;
	res_item_t        res_nxt;
	res_item_t        res_s2;
	logic             vld_s2;
	logic             adv;

	i2cms_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.ack_timeout (ack_timeout)
	);

	i2cms_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.ack_timeout (ack_timeout),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// Stage 1 moves into the result register when that slot frees up
	assign adv       = vld_s1 && (!vld_s2 || res.ready);
	assign cmd.ready = !vld_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= '{mode: cmd.mode, sda_sample: cmd.sda_sample, tx_byte: cmd.tx_byte,
				lsb_first: cmd.lsb_first, send_ack: cmd.send_ack};
		end
	end

	// Sequencer state, updated once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{cmd: CMD_IDLE, phase: 2'd0, bit_cnt: 4'd0, shift: 8'd0,
				wait_cnt: 9'd0, scl: 1'b1, sda: 1'b1, sda_en: 1'b0, ack_sel: 1'b0,
				lsb_sel: 1'b0, err: 1'b0, rx_hold: 8'd0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign res.valid       = vld_s2;
	assign res.scl_level   = res_s2.scl_level;
	assign res.sda_level   = res_s2.sda_level;
	assign res.sda_drive   = res_s2.sda_drive;
	assign res.busy_res    = res_s2.busy_res;
	assign res.done_res    = res_s2.done_res;
	assign res.rx_byte     = res_s2.rx_byte;
	assign res.ack_missing = res_s2.ack_missing;

`ifndef SYNTHESIS
	// A finished command never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done and busy reported together");

	// Released SDA reads high
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !res_s2.sda_drive |-> res_s2.sda_level)
		else $error("SDA low while released");

	// Idle state carries no phase or bit progress
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cmd == CMD_IDLE |-> state_q.phase == 2'd0 && state_q.bit_cnt == 4'd0)
		else $error("idle with leftover phase");

	// A timeout hands over to the stop sequence
	a_timeout_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.err) |-> state_q.cmd == CMD_STOP)
		else $error("ack timeout without stop");

	// State only changes when a transaction is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv) |-> $stable(state_q))
		else $error("state changed without a transaction");
`endif

endmodule

// File: tb/i2c_master_bit_sequencer_unit_test.sv
module i2c_master_bit_sequencer_unit_test;
	import i2cms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] MODE_TICK   = CMD_IDLE;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	localparam logic [PADDR_W-1:0] ADDR_ACK_TIMEOUT = {REG_ACK_TIMEOUT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNUSED      = {~REG_ACK_TIMEOUT, 2'b00};

	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT  = 200;
	localparam int NUM_PHASES   = 5;

	// timeout, SDA high percentage, active transactions per phase
	localparam int PHASE_TIMEOUT [NUM_PHASES] = '{250, 1, 255, 2, 0};
	localparam int PHASE_SDA_PCT [NUM_PHASES] = '{60, 70, 100, 80, 75};
	localparam int PHASE_QUOTA   [NUM_PHASES] = '{220, 220, 300, 220, 220};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	i2cms_cmd_if cmd_ch ();
	i2cms_res_if res_ch ();

	i2c_master_bit_sequencer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Directed vector: item, whether the result is written out, and whether
	// ticks follow until the command completes
	typedef struct {
		cmd_item_t item;
		bit        typed;
		bit        to_idle;
		res_item_t want;
	} vector_t;

	// fields: mode, sda, tx, lsb, ack / scl, sda, drive, busy, done, rx, ack_missing
	vector_t directed_vectors [19] = '{
		'{'{MODE_TICK,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{'{MODE_SPARE6, 1'b1, 8'hFF, 1'b1, 1'b1}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{'{MODE_SPARE7, 1'b0, 8'h5A, 1'b0, 1'b1}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{'{CMD_START,   1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		// command while busy acts as a tick
		'{'{CMD_STOP,    1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{'{MODE_TICK,   1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{'{CMD_STOP,    1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{'{MODE_TICK,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{'{MODE_TICK,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// acknowledge seen on the first sample
		'{'{CMD_WAIT,    1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
		// zero timeout: first high sample already times out, stop follows
		'{'{CMD_WAIT,    1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
		'{'{MODE_TICK,   1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
		'{'{MODE_TICK,   1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
		'{'{MODE_TICK,   1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		// idle tick holds the pins
		'{'{MODE_TICK,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0,
			'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
		'{'{CMD_WRITE,   1'b0, 8'h80, 1'b0, 1'b0}, 1'b0, 1'b1, '0},
		'{'{CMD_WRITE,   1'b1, 8'h01, 1'b1, 1'b0}, 1'b0, 1'b1, '0},
		'{'{CMD_READ,    1'b1, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b1, '0},
		'{'{CMD_READ,    1'b0, 8'hFF, 1'b1, 1'b0}, 1'b0, 1'b1, '0}
	};

	// Sequencer copy, at reset values
	cmd_t       seq_cmd   = CMD_IDLE;
	logic [1:0] seq_phase = '0;
	logic [3:0] bit_cnt   = '0;
	logic [7:0] shreg     = '0;
	logic [8:0] wait_cnt  = '0;
	logic       scl_q     = 1'b1;
	logic       sda_q     = 1'b1;
	logic       sda_en_q  = 1'b0;
	logic       ack_sel   = 1'b0;
	logic       lsb_sel   = 1'b0;
	logic       err_q     = 1'b0;
	logic [7:0] rx_q      = '0;
	logic [7:0] timeout_q = TIMEOUT_RESET;

	res_item_t expected_bus_states [$];
	int        mismatch_count     = 0;
	int        reg_mismatch_count = 0;
	int        active_items       = 0;
	bit        tx_steady          = 1'b0;
	bit        rx_steady          = 1'b0;

	// Advance the sequencer copy by one bus phase
	function automatic res_item_t step_sequencer(cmd_item_t it);
		res_item_t r;
		logic      done;
		done = 1'b0;
		if (seq_cmd == CMD_IDLE && it.mode >= CMD_START && it.mode <= CMD_WAIT) begin
			seq_cmd   = cmd_t'(it.mode);
			seq_phase = '0;
			bit_cnt   = '0;
			wait_cnt  = '0;
			err_q     = 1'b0;
			shreg     = (it.mode == CMD_WRITE) ? it.tx_byte : 8'h00;
			lsb_sel   = it.lsb_first;
			ack_sel   = it.send_ack;
		end
		case (seq_cmd)
			CMD_START: begin
				if (seq_phase == 2'd0) begin
					sda_en_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; seq_phase = 2'd1;
				end else if (seq_phase == 2'd1) begin
					sda_q = 1'b0; seq_phase = 2'd2;
				end else begin
					scl_q = 1'b0; done = 1'b1;
				end
			end
			CMD_STOP: begin
				if (seq_phase == 2'd0) begin
					sda_en_q = 1'b1; sda_q = 1'b0; scl_q = 1'b0; seq_phase = 2'd1;
				end else if (seq_phase == 2'd1) begin
					scl_q = 1'b1; seq_phase = 2'd2;
				end else begin
					sda_q = 1'b1; done = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (bit_cnt < BITS_PER_BYTE) begin
					if (seq_phase == 2'd0) begin
						sda_en_q = 1'b1;
						scl_q    = 1'b0;
						if (lsb_sel) begin
							sda_q = shreg[0];
							shreg = shreg >> 1;
						end else begin
							sda_q = shreg[7];
							shreg = shreg << 1;
						end
						seq_phase = 2'd1;
					end else begin
						scl_q = 1'b1; seq_phase = 2'd0; bit_cnt++;
					end
				end else begin
					scl_q = 1'b0; done = 1'b1;
				end
			end
			CMD_READ: begin
				if (bit_cnt < BITS_PER_BYTE) begin
					if (seq_phase == 2'd0) begin
						scl_q = 1'b0; sda_en_q = 1'b0; sda_q = 1'b1; seq_phase = 2'd1;
					end else begin
						scl_q     = 1'b1;
						shreg     = {shreg[6:0], it.sda_sample};
						bit_cnt++;
						seq_phase = 2'd0;
						if (bit_cnt == BITS_PER_BYTE)
							rx_q = shreg;
					end
				end else if (seq_phase == 2'd0) begin
					// acknowledge bit: low for ACK, high for NACK
					scl_q = 1'b0; sda_en_q = 1'b1; sda_q = ~ack_sel; seq_phase = 2'd1;
				end else if (seq_phase == 2'd1) begin
					scl_q = 1'b1; seq_phase = 2'd2;
				end else begin
					scl_q = 1'b0; done = 1'b1;
				end
			end
			CMD_WAIT: begin
				if (seq_phase == 2'd0) begin
					sda_en_q = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
					wait_cnt = '0; seq_phase = 2'd1;
				end
				if (!it.sda_sample) begin
					scl_q = 1'b0; done = 1'b1;
				end else begin
					if (wait_cnt < WAIT_MAX)
						wait_cnt++;
					// timed out: flag it and hand over to a stop sequence
					if (wait_cnt > {1'b0, timeout_q}) begin
						err_q     = 1'b1;
						seq_cmd   = CMD_STOP;
						seq_phase = '0;
						bit_cnt   = '0;
					end
				end
			end
			default: ;
		endcase
		if (done) begin
			seq_cmd   = CMD_IDLE;
			seq_phase = '0;
			bit_cnt   = '0;
		end
		r.scl_level   = scl_q;
		r.sda_level   = sda_en_q ? sda_q : 1'b1;
		r.sda_drive   = sda_en_q;
		r.busy_res    = (seq_cmd != CMD_IDLE);
		r.done_res    = done;
		r.rx_byte     = rx_q;
		r.ack_missing = err_q;
		return r;
	endfunction

	// Random transaction: mostly well-formed commands followed by ticks
	function automatic cmd_item_t draw_item(int sda_pct);
		cmd_item_t it;
		int        pick;
		it.sda_sample = ($urandom_range(0, 99) < sda_pct);
		it.tx_byte    = 8'($urandom_range(0, 255));
		it.lsb_first  = 1'($urandom_range(0, 1));
		it.send_ack   = 1'($urandom_range(0, 1));
		pick          = $urandom_range(0, 99);
		if (seq_cmd == CMD_IDLE) begin
			if (pick < 4)
				it.mode = MODE_TICK;
			else if (pick < 7)
				it.mode = MODE_SPARE6;
			else if (pick < 10)
				it.mode = MODE_SPARE7;
			else
				it.mode = 3'($urandom_range(int'(CMD_START), int'(CMD_WAIT)));
		end else begin
			it.mode = (pick < 5) ? 3'($urandom_range(1, 7)) : MODE_TICK;
		end
		return it;
	endfunction

	// Present one transaction, predict it on acceptance, then draw the next gap
	task automatic send_item(input cmd_item_t it, input bit typed, input res_item_t want);
		res_item_t predicted;
		int        gap;
		bit        rdy;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.mode       <= it.mode;
		cmd_ch.sda_sample <= it.sda_sample;
		cmd_ch.tx_byte    <= it.tx_byte;
		cmd_ch.lsb_first  <= it.lsb_first;
		cmd_ch.send_ack   <= it.send_ack;
		// ready is sampled mid-cycle, where it holds its value for the coming edge
		do begin
			@(negedge clk);
			rdy = cmd_ch.ready;
			@(posedge clk);
		end while (!rdy);
		predicted = step_sequencer(it);
		expected_bus_states.push_back(typed ? want : predicted);
		if (predicted.busy_res || predicted.done_res)
			active_items++;
		if ($urandom_range(0, 29) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and let every outstanding result arrive
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (expected_bus_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_ACK_TIMEOUT)
			timeout_q = value;
	endtask

	// Read the timeout register back and compare
	task automatic check_timeout_reg();
		logic [7:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_ACK_TIMEOUT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got     = prdata[7:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== timeout_q) begin
			$error("ack_timeout: expected %0d, got %0d", timeout_q, got);
			reg_mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: random ready stalls, compare against oldest expectation
	initial begin : result_sink
		res_item_t got;
		res_item_t want;
		int        hold;
		bit        vld;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_steady = !rx_steady;
			hold = rx_steady ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			// valid and payload are sampled mid-cycle, ahead of the accepting edge
			do begin
				@(negedge clk);
				vld = res_ch.valid;
				got = {res_ch.scl_level, res_ch.sda_level, res_ch.sda_drive, res_ch.busy_res,
					res_ch.done_res, res_ch.rx_byte, res_ch.ack_missing};
				@(posedge clk);
			end while (!vld);
			if (expected_bus_states.size() == 0) begin
				$error("unexpected result transaction: %h", got);
				mismatch_count++;
			end else begin
				want = expected_bus_states.pop_front();
				if (got.scl_level !== want.scl_level) begin
					$error("scl_level: expected %0d, got %0d", want.scl_level, got.scl_level);
					mismatch_count++;
				end
				if (got.sda_level !== want.sda_level) begin
					$error("sda_level: expected %0d, got %0d", want.sda_level, got.sda_level);
					mismatch_count++;
				end
				if (got.sda_drive !== want.sda_drive) begin
					$error("sda_drive: expected %0d, got %0d", want.sda_drive, got.sda_drive);
					mismatch_count++;
				end
				if (got.busy_res !== want.busy_res) begin
					$error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
					mismatch_count++;
				end
				if (got.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
					mismatch_count++;
				end
				if (got.rx_byte !== want.rx_byte) begin
					$error("rx_byte: expected %h, got %h", want.rx_byte, got.rx_byte);
					mismatch_count++;
				end
				if (got.ack_missing !== want.ack_missing) begin
					$error("ack_missing: expected %0d, got %0d", want.ack_missing,
						got.ack_missing);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction ends the run
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(negedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		cmd_item_t tick;
		int        first;
		int        tmo;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.mode       <= MODE_TICK;
		cmd_ch.sda_sample <= 1'b1;
		cmd_ch.tx_byte    <= '0;
		cmd_ch.lsb_first  <= 1'b0;
		cmd_ch.send_ack   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// register after reset, unused index ignored, then zero timeout
		check_timeout_reg();
		apb_write(ADDR_UNUSED, 8'($urandom_range(0, 255)));
		check_timeout_reg();
		apb_write(ADDR_ACK_TIMEOUT, 8'd0);
		check_timeout_reg();

		// directed vectors
		foreach (directed_vectors[i]) begin
			send_item(directed_vectors[i].item, directed_vectors[i].typed,
				directed_vectors[i].want);
			if (directed_vectors[i].to_idle) begin
				tick      = directed_vectors[i].item;
				tick.mode = MODE_TICK;
				while (seq_cmd != CMD_IDLE)
					send_item(tick, 1'b0, '0);
			end
		end

		// random phases, each at its own timeout setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			tmo = (PHASE_TIMEOUT[p] == 0) ? $urandom_range(1, 255) : PHASE_TIMEOUT[p];
			apb_write(ADDR_ACK_TIMEOUT, 8'(tmo));
			check_timeout_reg();
			first = active_items;
			while (active_items - first < PHASE_QUOTA[p] || seq_cmd != CMD_IDLE)
				send_item(draw_item(PHASE_SDA_PCT[p]), 1'b0, '0);
		end

		drain();
		if (mismatch_count == 0 && reg_mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_if.sv
hdl/i2cms_regs.sv
hdl/i2cms_step.sv
hdl/i2c_master_bit_sequencer_unit.sv
tb/i2c_master_bit_sequencer_unit_test.sv
